// ===== design/ifs_pkg.sv =====
package ifs_pkg;

    // Configuration port geometry
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    // Slot limits for a tick to be serviced
    localparam logic [7:0] PALETTE_SLOTS = 8'd20;
    localparam logic [7:0] MAP_SLOTS     = 8'd8;

    // Hardware ceiling on frames, set by the 3-bit frame index
    localparam int unsigned FRAME_CEIL = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_COUNT  = 3'd0,
        REG_FRAME_SPEEDS = 3'd1,
        REG_PING_PONG    = 3'd2,
        REG_START_FRAME  = 3'd3,
        REG_LOADED_FLAG  = 3'd4
    } t_reg_idx;

    typedef enum logic [1:0] {
        STATUS_OK         = 2'd0,
        STATUS_NOT_LOADED = 2'd1,
        STATUS_BAD_SLOT   = 2'd2
    } t_status;

    // Configuration as seen by the animation core
    typedef struct packed {
        logic [3:0]  frame_count;
        logic [15:0] frame_speeds;
        logic        ping_pong;
        logic        loaded;
        logic        start_load;
        logic [2:0]  start_frame;
    } t_cfg;

endpackage

// ===== design/ifs_tick_if.sv =====
interface ifs_tick_if;
    logic       valid;
    logic       ready;
    logic [7:0] palette_slot;
    logic [7:0] map_slot;
    logic [1:0] wrap_s_mode;
    logic [1:0] wrap_t_mode;

    modport source (
        output valid, palette_slot, map_slot, wrap_s_mode, wrap_t_mode,
        input  ready
    );
    modport sink (
        input  valid, palette_slot, map_slot, wrap_s_mode, wrap_t_mode,
        output ready
    );
endinterface

// ===== design/ifs_result_if.sv =====
interface ifs_result_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [2:0] frame_index;
    logic [2:0] map_out;
    logic [1:0] wrap_s_out;
    logic [1:0] wrap_t_out;

    modport source (
        output valid, status, frame_index, map_out, wrap_s_out, wrap_t_out,
        input  ready
    );
    modport sink (
        input  valid, status, frame_index, map_out, wrap_s_out, wrap_t_out,
        output ready
    );
endinterface

// ===== design/ifs_cfg_regs.sv =====
module ifs_cfg_regs
    import ifs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    logic [3:0]  r_frame_count;
    logic [15:0] r_frame_speeds;
    logic        r_ping_pong;
    logic        r_loaded;
    t_reg_idx    w_idx;

    assign w_idx = t_reg_idx'(i_cfg_idx);

    // Decode register writes; unknown indexes drop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_count  <= 4'd1;
            r_frame_speeds <= 16'd0;
            r_ping_pong    <= 1'b0;
            r_loaded       <= 1'b0;
        end else if (i_cfg_we) begin
            case (w_idx)
                REG_FRAME_COUNT:  r_frame_count  <= i_cfg_data[3:0];
                REG_FRAME_SPEEDS: r_frame_speeds <= i_cfg_data[15:0];
                REG_PING_PONG:    r_ping_pong    <= i_cfg_data[0];
                REG_LOADED_FLAG:  r_loaded       <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Start frame acts only as a load strobe into the frame register
    assign o_cfg.frame_count  = r_frame_count;
    assign o_cfg.frame_speeds = r_frame_speeds;
    assign o_cfg.ping_pong    = r_ping_pong;
    assign o_cfg.loaded       = r_loaded;
    assign o_cfg.start_load   = i_cfg_we && (w_idx == REG_START_FRAME);
    assign o_cfg.start_frame  = i_cfg_data[2:0];

endmodule

// ===== design/ifs_anim_core.sv =====
module ifs_anim_core
    import ifs_pkg::*;
#(
    parameter int unsigned MAX_FRAMES  = 8,
    parameter int unsigned TICK_DIVIDE = 5
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  t_cfg       i_cfg,
    output logic [2:0] o_frame
);

    localparam int unsigned FRAME_LIMIT = (MAX_FRAMES < FRAME_CEIL) ? MAX_FRAMES : FRAME_CEIL;
    localparam logic [3:0]  LIMIT_4     = 4'(FRAME_LIMIT);
    localparam logic [2:0]  PRESCALE_LD = 3'(TICK_DIVIDE);

    logic [2:0] r_pre,  n_pre;
    logic [2:0] r_hold, n_hold;
    logic [2:0] r_frame, n_frame;
    logic       r_back, n_back;

    logic [3:0] w_count;
    logic [2:0] w_last;
    logic       w_at_end;
    logic [1:0] w_speed;
    logic [2:0] w_pre_dec;

    // Clamp the frame count into 1..limit
    always_comb begin
        if (i_cfg.frame_count == 4'd0) begin
            w_count = 4'd1;
        end else if (i_cfg.frame_count > LIMIT_4) begin
            w_count = LIMIT_4;
        end else begin
            w_count = i_cfg.frame_count;
        end
    end

    assign w_last    = 3'(w_count - 4'd1);
    assign w_at_end  = ({1'b0, r_frame} + 4'd1) >= w_count;
    assign w_speed   = i_cfg.frame_speeds[{r_frame, 1'b0} +: 2];
    assign w_pre_dec = r_pre - 3'd1;

    // Prescale, hold and frame advance for one serviced tick
    always_comb begin
        n_pre   = r_pre;
        n_hold  = r_hold;
        n_frame = r_frame;
        n_back  = r_back;
        if (i_step) begin
            n_pre = w_pre_dec;
            if (w_pre_dec == 3'd0) begin
                n_pre  = PRESCALE_LD;
                n_hold = r_hold + 3'd1;
                if (r_hold > {1'b0, w_speed}) begin
                    n_hold = 3'd0;
                    if (i_cfg.ping_pong) begin
                        if (!r_back) begin
                            if (w_at_end) begin
                                n_frame = w_last;
                                n_back  = 1'b1;
                            end else begin
                                n_frame = r_frame + 3'd1;
                            end
                        end else if (r_frame == 3'd0) begin
                            n_back = 1'b0;
                        end else begin
                            n_frame = r_frame - 3'd1;
                        end
                    end else if (w_at_end) begin
                        n_frame = 3'd0;
                    end else begin
                        n_frame = r_frame + 3'd1;
                    end
                end
            end
        end
    end

    // Hold state; a start-frame write loads the frame only
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pre   <= PRESCALE_LD;
            r_hold  <= 3'd0;
            r_frame <= 3'd0;
            r_back  <= 1'b0;
        end else begin
            r_pre  <= n_pre;
            r_hold <= n_hold;
            r_back <= n_back;
            if (i_cfg.start_load) begin
                r_frame <= i_cfg.start_frame;
            end else begin
                r_frame <= n_frame;
            end
        end
    end

    assign o_frame = n_frame;

    // Hold count clears once it passes a 2-bit speed
    a_hold_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hold <= 3'd4)
        else $error("hold count out of range");

    // Prescaler never rests at zero nor above its reload
    a_pre_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pre != 3'd0) && (r_pre <= PRESCALE_LD))
        else $error("prescaler out of range");

    // Without a tick or a load, frame and direction hold
    a_idle_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_step && !i_cfg.start_load) |=> ($stable(r_frame) && $stable(r_back)))
        else $error("frame moved without a tick");

    // A frame change by a tick always clears the hold count
    a_adv_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && !i_cfg.start_load && (n_frame != r_frame)) |=> (r_hold == 3'd0))
        else $error("frame advanced without clearing hold");

endmodule

// ===== design/icon_frame_sequencer.sv =====
// Icon frame sequencer: picks the animation frame for each display tick.
//
// i_tick carries one beat per display tick (palette slot, map slot, wrap
// modes); o_result returns exactly one beat per tick with status, frame
// index, map slot and wrap modes. Both channels use valid/ready.
// The configuration port (i_cfg_we, i_cfg_idx, i_cfg_data) writes one
// register per cycle; write it only while no tick is in flight.
//
// Throughput: one tick per cycle while o_result is ready; the tick is
// held in an input register and its result lands in an output register,
// so a new tick is taken while a result waits as long as the input
// register is free.
// When o_result stalls, at most two ticks are held (one per register),
// then i_tick.ready drops; nothing is lost or repeated.
//
// Reset (synchronous, active low) empties both registers, loads the
// prescaler with TICK_DIVIDE, clears hold count, frame and direction, and
// restores the registers to: one frame, zero speeds, wrap mode, not loaded.
module icon_frame_sequencer
    import ifs_pkg::*;
#(
    parameter int unsigned MAX_FRAMES  = 8,
    parameter int unsigned TICK_DIVIDE = 5
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    ifs_tick_if.sink              i_tick,
    ifs_result_if.source          o_result,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg       w_cfg;
    logic       w_adv;
    logic       w_fire;
    logic       w_slot_ok;
    logic [2:0] w_frame;
    t_status    w_status;

    logic       r_in_valid;
    logic [7:0] r_palette;
    logic [7:0] r_map;
    logic [1:0] r_wrap_s;
    logic [1:0] r_wrap_t;

    logic       r_out_valid;
    t_status    r_status;
    logic [2:0] r_frame_out;
    logic [2:0] r_map_out;
    logic [1:0] r_wrap_s_out;
    logic [1:0] r_wrap_t_out;

    ifs_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    // Input stage moves on when the output register frees up
    assign w_adv        = !r_out_valid || o_result.ready;
    assign i_tick.ready = !r_in_valid || w_adv;
    assign w_fire       = r_in_valid && w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_tick.ready) begin
            r_in_valid <= i_tick.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_tick.valid && i_tick.ready) begin
            r_palette <= i_tick.palette_slot;
            r_map     <= i_tick.map_slot;
            r_wrap_s  <= i_tick.wrap_s_mode;
            r_wrap_t  <= i_tick.wrap_t_mode;
        end
    end

    // Classify the tick: not loaded wins over bad slots
    assign w_slot_ok = (r_palette < PALETTE_SLOTS) && (r_map < MAP_SLOTS);

    always_comb begin
        if (!w_cfg.loaded) begin
            w_status = STATUS_NOT_LOADED;
        end else if (!w_slot_ok) begin
            w_status = STATUS_BAD_SLOT;
        end else begin
            w_status = STATUS_OK;
        end
    end

    ifs_anim_core #(
        .MAX_FRAMES  (MAX_FRAMES),
        .TICK_DIVIDE (TICK_DIVIDE)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_fire && (w_status == STATUS_OK)),
        .i_cfg   (w_cfg),
        .o_frame (w_frame)
    );

    // Output register; error beats carry zero fields
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_status <= w_status;
            if (w_status == STATUS_OK) begin
                r_frame_out  <= w_frame;
                r_map_out    <= r_map[2:0];
                r_wrap_s_out <= r_wrap_s;
                r_wrap_t_out <= r_wrap_t;
            end else begin
                r_frame_out  <= 3'd0;
                r_map_out    <= 3'd0;
                r_wrap_s_out <= 2'd0;
                r_wrap_t_out <= 2'd0;
            end
        end
    end

    assign o_result.valid       = r_out_valid;
    assign o_result.status      = r_status;
    assign o_result.frame_index = r_frame_out;
    assign o_result.map_out     = r_map_out;
    assign o_result.wrap_s_out  = r_wrap_s_out;
    assign o_result.wrap_t_out  = r_wrap_t_out;

    // Error beats never carry a frame or a slot
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_status != STATUS_OK)) |->
        ((r_frame_out == 3'd0) && (r_map_out == 3'd0)))
        else $error("error beat carries payload");

    // A stalled output with a full input stage blocks new ticks
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !o_result.ready) |-> !i_tick.ready)
        else $error("tick taken while both stages full");

endmodule
